[design/sckev_pkg.sv]
// shared types, constants and us-layout translation tables for the scancode decoder
`default_nettype none
package sckev_pkg;

    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam int         CODE_W      = 7;
    localparam int         ASCII_W     = 7;

    localparam logic [CODE_W-1:0] LSHIFT_CODE = 7'h2A;
    localparam logic [CODE_W-1:0] RSHIFT_CODE = 7'h36;
    localparam logic [CODE_W-1:0] CTRL_CODE   = 7'h1D;
    localparam logic [CODE_W-1:0] ALT_CODE    = 7'h38;
    localparam logic [CODE_W-1:0] CAPS_CODE   = 7'h3A;

    localparam logic [ASCII_W-1:0] NO_CHAR     = 7'h00;
    localparam logic [ASCII_W-1:0] LOWER_A     = 7'h61;
    localparam logic [ASCII_W-1:0] LOWER_Z     = 7'h7A;
    localparam logic [ASCII_W-1:0] UPPER_A     = 7'h41;
    localparam logic [ASCII_W-1:0] UPPER_Z     = 7'h5A;
    localparam logic [ASCII_W-1:0] CASE_OFFSET = 7'h20;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
    } mod_state_t;

    function automatic logic [ASCII_W-1:0] plain_char(input logic [CODE_W-1:0] code);
        logic [ASCII_W-1:0] ch;
        case (code)
            7'h02: ch = 7'h31; 7'h03: ch = 7'h32; 7'h04: ch = 7'h33; 7'h05: ch = 7'h34;
            7'h06: ch = 7'h35; 7'h07: ch = 7'h36; 7'h08: ch = 7'h37; 7'h09: ch = 7'h38;
            7'h0A: ch = 7'h39; 7'h0B: ch = 7'h30; 7'h0C: ch = 7'h2D; 7'h0D: ch = 7'h3D;
            7'h0E: ch = 7'h08; 7'h0F: ch = 7'h09;
            7'h10: ch = 7'h71; 7'h11: ch = 7'h77; 7'h12: ch = 7'h65; 7'h13: ch = 7'h72;
            7'h14: ch = 7'h74; 7'h15: ch = 7'h79; 7'h16: ch = 7'h75; 7'h17: ch = 7'h69;
            7'h18: ch = 7'h6F; 7'h19: ch = 7'h70; 7'h1A: ch = 7'h5B; 7'h1B: ch = 7'h5D;
            7'h1C: ch = 7'h0A;
            7'h1E: ch = 7'h61; 7'h1F: ch = 7'h73; 7'h20: ch = 7'h64; 7'h21: ch = 7'h66;
            7'h22: ch = 7'h67; 7'h23: ch = 7'h68; 7'h24: ch = 7'h6A; 7'h25: ch = 7'h6B;
            7'h26: ch = 7'h6C; 7'h27: ch = 7'h3B; 7'h28: ch = 7'h27; 7'h29: ch = 7'h60;
            7'h2B: ch = 7'h5C;
            7'h2C: ch = 7'h7A; 7'h2D: ch = 7'h78; 7'h2E: ch = 7'h63; 7'h2F: ch = 7'h76;
            7'h30: ch = 7'h62; 7'h31: ch = 7'h6E; 7'h32: ch = 7'h6D; 7'h33: ch = 7'h2C;
            7'h34: ch = 7'h2E; 7'h35: ch = 7'h2F; 7'h39: ch = 7'h20;
            default: ch = NO_CHAR;
        endcase
        return ch;
    endfunction

    function automatic logic [ASCII_W-1:0] shifted_char(input logic [CODE_W-1:0] code);
        logic [ASCII_W-1:0] ch;
        case (code)
            7'h02: ch = 7'h21; 7'h03: ch = 7'h40; 7'h04: ch = 7'h23; 7'h05: ch = 7'h24;
            7'h06: ch = 7'h25; 7'h07: ch = 7'h5E; 7'h08: ch = 7'h26; 7'h09: ch = 7'h2A;
            7'h0A: ch = 7'h28; 7'h0B: ch = 7'h29; 7'h0C: ch = 7'h5F; 7'h0D: ch = 7'h2B;
            7'h0E: ch = 7'h08; 7'h0F: ch = 7'h09;
            7'h10: ch = 7'h51; 7'h11: ch = 7'h57; 7'h12: ch = 7'h45; 7'h13: ch = 7'h52;
            7'h14: ch = 7'h54; 7'h15: ch = 7'h59; 7'h16: ch = 7'h55; 7'h17: ch = 7'h49;
            7'h18: ch = 7'h4F; 7'h19: ch = 7'h50; 7'h1A: ch = 7'h7B; 7'h1B: ch = 7'h7D;
            7'h1C: ch = 7'h0A;
            7'h1E: ch = 7'h41; 7'h1F: ch = 7'h53; 7'h20: ch = 7'h44; 7'h21: ch = 7'h46;
            7'h22: ch = 7'h47; 7'h23: ch = 7'h48; 7'h24: ch = 7'h4A; 7'h25: ch = 7'h4B;
            7'h26: ch = 7'h4C; 7'h27: ch = 7'h3A; 7'h28: ch = 7'h22; 7'h29: ch = 7'h7E;
            7'h2B: ch = 7'h7C;
            7'h2C: ch = 7'h5A; 7'h2D: ch = 7'h58; 7'h2E: ch = 7'h43; 7'h2F: ch = 7'h56;
            7'h30: ch = 7'h42; 7'h31: ch = 7'h4E; 7'h32: ch = 7'h4D; 7'h33: ch = 7'h3C;
            7'h34: ch = 7'h3E; 7'h35: ch = 7'h3F; 7'h39: ch = 7'h20;
            default: ch = NO_CHAR;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

[design/sckev_xlate.sv]
// make code to us ascii translation with shift table select, caps case flip and enable gating
`default_nettype none
module sckev_xlate (
    input  wire logic [sckev_pkg::CODE_W-1:0]  code,
    input  wire sckev_pkg::mod_state_t         mods,
    input  wire logic                          enable,
    output logic      [sckev_pkg::ASCII_W-1:0] ascii
);
    import sckev_pkg::*;

    logic [ASCII_W-1:0] table_ch;

    always_comb begin
        table_ch = mods.shift ? shifted_char(code) : plain_char(code);
        ascii    = table_ch;
        // caps flips letter case after the table pick
        if (mods.caps) begin
            if (table_ch >= LOWER_A && table_ch <= LOWER_Z) begin
                ascii = table_ch - CASE_OFFSET;
            end else if (table_ch >= UPPER_A && table_ch <= UPPER_Z) begin
                ascii = table_ch + CASE_OFFSET;
            end
        end
        if (!enable) begin
            ascii = NO_CHAR;
        end
    end

endmodule
`default_nettype wire

[design/scancode_to_key_event.sv]
// top level: ps/2 set-1 scancode byte stream to key event stream
//
// Takes one raw scancode byte per transaction on the s_ channel and gives one key
// event per transaction on the m_ channel for every byte except the 0xE0 prefix,
// which only marks the next byte as an extended key and produces nothing. Each
// event carries the make code (bit 7 set for extended keys), the us-layout ascii
// character (0 for releases, extended keys and unmapped codes), a press flag and
// the shift/ctrl/alt/caps state after the byte. The block sustains one byte per
// clock while m_ready stays high: a byte sits in an input register, where the
// modifier update and table lookup run as shallow logic, and its event then
// sits in the output register until taken. m_valid rises once the event is
// written from the input register into the output register, which can wait on
// m_ready. s_ready follows m_ready combinationally through the two-entry pipe.
`default_nettype none
module scancode_to_key_event (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_scan_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic      [7:0] m_key_code,
    output logic      [6:0] m_ascii_char,
    output logic            m_is_press,
    output logic            m_shift_flag,
    output logic            m_ctrl_flag,
    output logic            m_alt_flag,
    output logic            m_caps_flag
);
    import sckev_pkg::*;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // persistent decoder state
    mod_state_t mods_reg, mods_next;
    logic       ext_reg;

    // output stage
    logic               out_valid_reg;
    logic [7:0]         out_code_reg;
    logic [ASCII_W-1:0] out_ascii_reg;
    logic               out_press_reg;
    mod_state_t         out_mods_reg;

    logic               is_prefix;
    logic               release_bit;
    logic [CODE_W-1:0]  code;
    logic               out_free;
    logic               consume;
    logic               emit;
    logic [ASCII_W-1:0] ascii;

    assign is_prefix   = (in_byte_reg == PREFIX_BYTE);
    assign release_bit = in_byte_reg[7];
    assign code        = in_byte_reg[CODE_W-1:0];

    // output register can take a new event when empty or being drained
    assign out_free = !out_valid_reg || m_ready;
    // a prefix byte never needs the output register
    assign consume  = in_valid_reg && (is_prefix || out_free);
    assign emit     = consume && !is_prefix;
    assign s_ready  = !in_valid_reg || consume;

    // modifier update from the make code, extended or not
    always_comb begin
        mods_next = mods_reg;
        if (code == LSHIFT_CODE || code == RSHIFT_CODE) begin
            mods_next.shift = !release_bit;
        end else if (code == CTRL_CODE) begin
            mods_next.ctrl = !release_bit;
        end else if (code == ALT_CODE) begin
            mods_next.alt = !release_bit;
        end else if (code == CAPS_CODE && !release_bit) begin
            mods_next.caps = !mods_reg.caps;
        end
    end

    // only plain presses get a character
    sckev_xlate u_xlate (
        .code   (code),
        .mods   (mods_next),
        .enable (!release_bit && !ext_reg),
        .ascii  (ascii)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mods_reg      <= '0;
            ext_reg       <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (consume) begin
                if (is_prefix) begin
                    ext_reg <= 1'b1;
                end else begin
                    ext_reg  <= 1'b0;
                    mods_reg <= mods_next;
                end
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_scan_byte;
        end
        if (emit) begin
            out_code_reg  <= {ext_reg, code};
            out_ascii_reg <= ascii;
            out_press_reg <= !release_bit;
            out_mods_reg  <= mods_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_key_code   = out_code_reg;
    assign m_ascii_char = out_ascii_reg;
    assign m_is_press   = out_press_reg;
    assign m_shift_flag = out_mods_reg.shift;
    assign m_ctrl_flag  = out_mods_reg.ctrl;
    assign m_alt_flag   = out_mods_reg.alt;
    assign m_caps_flag  = out_mods_reg.caps;

endmodule
`default_nettype wire
